FILE: rtl/fast10_pkg.sv
// Shared types and constants for the FAST-10 corner detector.
// No dependencies; used by fast10_corner_detector_top.
`default_nettype none

package fast10_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [7:0]  THRESHOLD_RST    = 8'd20;
    localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int CX_W     = 11;
    localparam int CY_W     = 16;
    localparam int LINE_W   = 48;
    localparam int OUT_DATA_W = 32;

    typedef logic [PIX_W-1:0] t_pixel;
    // Window indexed [row][column], row 0 is the oldest line
    typedef logic [6:0][6:0][PIX_W-1:0] t_window;

    // Radius-3 Bresenham circle, clockwise from the top, as window row/column
    localparam logic [2:0] CIRC_ROW [16] = '{
        3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };
    localparam logic [2:0] CIRC_COL [16] = '{
        3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
        3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2
    };

endpackage

`default_nettype wire

FILE: rtl/fast10_corner_detector_top.sv
// FAST-10 corner detector: line store, 7x7 window and segment test; needs fast10_pkg.
// Order: an input transfer passes the line store read, the window shift and the result register.
// Throughput: one pixel per cycle while the output is not stalled; the line store takes one
// read and one write a cycle, with a one-entry bypass for back-to-back transfers to the same column.
// Reset: counters cleared, window zeroed, registers to defaults; the line store
// is not cleared and needs no clearing pass.
`default_nettype none

module fast10_corner_detector_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [fast10_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fast10_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // pixel stream in
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [7:0]                         i_s_tdata,  // [7:0] pixel
    input  wire logic [0:0]                         i_s_tuser,  // [0] frame_start
    // corner stream out
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic [fast10_pkg::OUT_DATA_W-1:0]       o_m_tdata   // [10:0] corner_x,
                                                                // [26:11] corner_y
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > 13) ? CW + 1 : 13;
    localparam int XW = (CW > fast10_pkg::CX_W) ? CW : fast10_pkg::CX_W;
    localparam int PW = fast10_pkg::PIX_W;

    // Configuration registers
    logic [7:0]  r_threshold;
    logic [11:0] r_width;
    logic [15:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= fast10_pkg::THRESHOLD_RST;
            r_width     <= fast10_pkg::IMAGE_WIDTH_RST;
            r_height    <= fast10_pkg::IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fast10_pkg::REG_THRESHOLD:    r_threshold <= i_cfg_wdata[7:0];
                fast10_pkg::REG_IMAGE_WIDTH:  r_width     <= i_cfg_wdata[11:0];
                fast10_pkg::REG_IMAGE_HEIGHT: r_height    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control: each stage moves when the next one can take it
    logic r_v1, r_v2, r_ov;
    logic en1, en2, en3, accept, move12;

    assign en3    = !r_ov || i_m_tready;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_s_tready = en1;
    assign accept = i_s_tvalid && en1;
    assign move12 = r_v1 && en2;

    // Effective frame geometry
    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;

    always_comb begin
        w_eff = WW'(r_width);
        if (w_eff == '0)
            w_eff = WW'(1);
        else if (w_eff > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        h_eff = (r_height == 16'd0) ? 16'd1 : r_height;
    end

    // Position counters
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic [CW-1:0] cur_col, n_col;
    logic [15:0]   cur_row, n_row;
    logic [WW-1:0] col_inc;
    logic [16:0]   row_inc;

    always_comb begin
        cur_col = i_s_tuser[0] ? '0 : r_col;
        cur_row = i_s_tuser[0] ? '0 : r_row;
        if (WW'(cur_col) >= w_eff)
            cur_col = '0;
        if (cur_row >= h_eff)
            cur_row = '0;
        col_inc = WW'(cur_col) + WW'(1);
        row_inc = {1'b0, cur_row} + 17'd1;
        n_col   = col_inc[CW-1:0];
        n_row   = cur_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, h_eff}) ? 16'd0 : row_inc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: line store read, pixel and position held
    logic [fast10_pkg::LINE_W-1:0] r_line_mem [MAX_WIDTH];
    logic [fast10_pkg::LINE_W-1:0] r_rd_data, r_byp_data, old_line, new_line;
    logic                          r_byp;
    logic [PW-1:0]                 r_pix1;
    logic [CW-1:0]                 r_x1;
    logic [15:0]                   r_y1;

    assign old_line = r_byp ? r_byp_data : r_rd_data;
    assign new_line = {r_pix1, old_line[fast10_pkg::LINE_W-1:PW]};

    // Memory: written as stage 1 hands over, read on input transfer
    always_ff @(posedge i_clk) begin
        if (move12)
            r_line_mem[r_x1] <= new_line;
        if (accept)
            r_rd_data <= r_line_mem[cur_col];
    end

    // Same-address bypass (single-column images)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp      <= move12 && (r_x1 == cur_col);
            r_byp_data <= new_line;
            r_pix1     <= i_s_tdata;
            r_x1       <= cur_col;
            r_y1       <= cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v1 <= 1'b0;
        else if (en1)
            r_v1 <= i_s_tvalid;
    end

    // Stage 2: window shift and new column
    fast10_pkg::t_window r_win;
    logic [CW-1:0]       r_x2;
    logic [15:0]         r_y2;
    logic                r_elig2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (move12) begin
            for (int r = 0; r < 7; r++) begin
                for (int c = 0; c < 6; c++)
                    r_win[r][c] <= r_win[r][c+1];
            end
            for (int r = 0; r < 6; r++)
                r_win[r][6] <= old_line[PW*r +: PW];
            r_win[6][6] <= r_pix1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move12) begin
            r_x2    <= r_x1;
            r_y2    <= r_y1;
            r_elig2 <= (WW'(r_x1) >= WW'(6)) && (r_y1 >= 16'd6);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v2 <= 1'b0;
        else if (en2)
            r_v2 <= r_v1;
    end

    // Segment test on the window
    logic [PW-1:0] centre, lo, hi;
    logic [PW:0]   sum;
    logic [15:0]   dark, bright, run_d, run_b;
    logic          corner;

    always_comb begin
        centre = r_win[3][3];
        lo     = (centre > r_threshold) ? centre - r_threshold : '0;
        sum    = {1'b0, centre} + {1'b0, r_threshold};
        hi     = sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
        for (int i = 0; i < 16; i++) begin
            dark[i]   = r_win[fast10_pkg::CIRC_ROW[i]][fast10_pkg::CIRC_COL[i]] < lo;
            bright[i] = r_win[fast10_pkg::CIRC_ROW[i]][fast10_pkg::CIRC_COL[i]] > hi;
        end
        // ten contiguous bits, cyclic
        for (int i = 0; i < 16; i++) begin
            run_d[i] = 1'b1;
            run_b[i] = 1'b1;
            for (int k = 0; k < 10; k++) begin
                run_d[i] = run_d[i] & dark[4'(i + k)];
                run_b[i] = run_b[i] & bright[4'(i + k)];
            end
        end
        corner = (run_d != '0) || (run_b != '0);
    end

    // Stage 3: result register
    logic [XW-1:0]             cx_full;
    logic [fast10_pkg::CX_W-1:0] r_cx;
    logic [fast10_pkg::CY_W-1:0] r_cy;

    assign cx_full = XW'(r_x2) - XW'(3);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_cx <= cx_full[fast10_pkg::CX_W-1:0];
            r_cy <= r_y2 - 16'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ov <= 1'b0;
        else if (en3)
            r_ov <= r_v2 && r_elig2 && corner;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(fast10_pkg::OUT_DATA_W - fast10_pkg::CX_W - fast10_pkg::CY_W){1'b0}},
                         r_cy, r_cx};

    // Checks
    // a reported row always lies inside the interior margin
    a_row_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[26:11] >= 16'd3))
        else $error("corner row outside interior");

    // a stalled result holds the item behind it in stage 2
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && r_v2) |=> (r_v2 && $stable(r_x2) && $stable(r_win)))
        else $error("stage 2 moved under output stall");

endmodule

`default_nettype wire
